FILE: design/assert_macros.svh
// Assertion macros shared by the blitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TBB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a consequent holds whenever its antecedent holds.
`define TBB_ASSERT_IMP(label, ante, cons, msg) \
  `TBB_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: design/tbb_pkg.sv
// Types and constants shared by the transparent bitmap blitter modules.
package tbb_pkg;

  localparam int unsigned RegCount    = 8;
  localparam int unsigned AddrWidth   = $clog2(RegCount) + 2;
  localparam int unsigned IndexWidth  = $clog2(RegCount);

  localparam logic [IndexWidth-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [IndexWidth-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [IndexWidth-1:0] REG_BITMAP_WIDTH  = 3'd2;
  localparam logic [IndexWidth-1:0] REG_BITMAP_HEIGHT = 3'd3;
  localparam logic [IndexWidth-1:0] REG_PIXEL_FORMAT  = 3'd4;
  localparam logic [IndexWidth-1:0] REG_KEY_COLOR     = 3'd5;
  localparam logic [IndexWidth-1:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [IndexWidth-1:0] REG_SCREEN_HEIGHT = 3'd7;

  localparam logic [15:0] SCREEN_WIDTH_RESET  = 16'd320;
  localparam logic [15:0] SCREEN_HEIGHT_RESET = 16'd240;
  localparam logic [15:0] PIXEL_ON            = 16'h0001;

  typedef enum logic {
    FMT_PAGE  = 1'b0,
    FMT_COLOR = 1'b1
  } pixel_format_e;

  typedef struct packed {
    logic [15:0]   origin_x;
    logic [15:0]   origin_y;
    logic [15:0]   bitmap_width;
    logic [15:0]   bitmap_height;
    pixel_format_e pixel_format;
    logic [15:0]   key_color;
    logic [15:0]   screen_width;
    logic [15:0]   screen_height;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pop;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
    logic last;
  } dp_status_t;

endpackage

FILE: design/tbb_regs.sv
// APB configuration register file of the blitter.
module tbb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tbb_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output tbb_pkg::cfg_t                  cfg_o
);
  import tbb_pkg::*;

  cfg_t                  cfg_q;
  logic [IndexWidth-1:0] index;
  logic                  wr_en;

  assign index  = paddr[AddrWidth-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.bitmap_width  <= '0;
      cfg_q.bitmap_height <= '0;
      cfg_q.pixel_format  <= FMT_PAGE;
      cfg_q.key_color     <= '0;
      cfg_q.screen_width  <= SCREEN_WIDTH_RESET;
      cfg_q.screen_height <= SCREEN_HEIGHT_RESET;
    end else if (wr_en) begin
      case (index)
        REG_ORIGIN_X:      cfg_q.origin_x      <= pwdata[15:0];
        REG_ORIGIN_Y:      cfg_q.origin_y      <= pwdata[15:0];
        REG_BITMAP_WIDTH:  cfg_q.bitmap_width  <= pwdata[15:0];
        REG_BITMAP_HEIGHT: cfg_q.bitmap_height <= pwdata[15:0];
        REG_PIXEL_FORMAT:  cfg_q.pixel_format  <= pixel_format_e'(pwdata[0]);
        REG_KEY_COLOR:     cfg_q.key_color     <= pwdata[15:0];
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[15:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_ORIGIN_X:      prdata = {16'd0, cfg_q.origin_x};
      REG_ORIGIN_Y:      prdata = {16'd0, cfg_q.origin_y};
      REG_BITMAP_WIDTH:  prdata = {16'd0, cfg_q.bitmap_width};
      REG_BITMAP_HEIGHT: prdata = {16'd0, cfg_q.bitmap_height};
      REG_PIXEL_FORMAT:  prdata = {31'd0, cfg_q.pixel_format};
      REG_KEY_COLOR:     prdata = {16'd0, cfg_q.key_color};
      REG_SCREEN_WIDTH:  prdata = {16'd0, cfg_q.screen_width};
      REG_SCREEN_HEIGHT: prdata = {16'd0, cfg_q.screen_height};
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: design/tbb_ctrl.sv
// Handshake controller state machine of the blitter.
module tbb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tbb_pkg::dp_status_t status_i,
  output tbb_pkg::ctrl_cmd_t  cmd_o
);
  import tbb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && status_i.has_result) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.pop   = out_ready_i;
        if (out_ready_i && status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/tbb_dp.sv
// Datapath of the blitter: position counters, coordinates and pending bits.
module tbb_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbb_pkg::cfg_t       cfg_i,
  input  logic [15:0]         source_word_i,
  input  tbb_pkg::ctrl_cmd_t  cmd_i,
  output tbb_pkg::dp_status_t status_o,
  output logic [16:0]         pixel_x_o,
  output logic [16:0]         pixel_y_o,
  output logic [15:0]         pixel_value_o,
  output logic                last_of_run_o
);
  import tbb_pkg::*;

  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [7:0]  mask_q, mask_d;
  logic [16:0] x_q, y_q;
  logic [15:0] val_q;

  logic        empty;
  logic [16:0] x_sum, y_page, y_row, h_plus, col_inc, row_inc;
  logic [13:0] pages;
  logic [15:0] rows_total;
  logic        key_pass;
  logic [7:0]  load_mask;
  logic [7:0]  mask_rest;
  logic [2:0]  bit_idx;

  always_comb begin
    empty      = (cfg_i.bitmap_width == '0) || (cfg_i.bitmap_height == '0);
    x_sum      = {1'b0, cfg_i.origin_x} + {1'b0, col_q};
    y_page     = {1'b0, cfg_i.origin_y} + {row_q[13:0], 3'b000};
    y_row      = {1'b0, cfg_i.origin_y} + {1'b0, row_q};
    h_plus     = {1'b0, cfg_i.bitmap_height} + 17'd7;
    pages      = h_plus[16:3];
    rows_total = (cfg_i.pixel_format == FMT_COLOR) ? cfg_i.bitmap_height : {2'b00, pages};
    col_inc    = {1'b0, col_q} + 17'd1;
    row_inc    = {1'b0, row_q} + 17'd1;
    key_pass   = (x_sum < {1'b0, cfg_i.screen_width}) &&
                 (y_row < {1'b0, cfg_i.screen_height}) &&
                 (source_word_i != cfg_i.key_color);

    if (empty) begin
      load_mask = '0;
    end else if (cfg_i.pixel_format == FMT_COLOR) begin
      load_mask = {7'd0, key_pass};
    end else begin
      load_mask = source_word_i[7:0];
    end

    // Column and row advance, wrapping at the bitmap's end.
    if (empty) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= {1'b0, cfg_i.bitmap_width}) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, rows_total}) ? '0 : row_inc[15:0];
    end else begin
      col_d = col_inc[15:0];
      row_d = row_q;
    end
  end

  // Lowest pending bit selects the row offset of the current write.
  always_comb begin
    bit_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_q[i]) begin
        bit_idx = 3'(i);
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - 8'd1);

  always_comb begin
    mask_d = mask_q;
    if (cmd_i.load) begin
      mask_d = load_mask;
    end else if (cmd_i.pop) begin
      mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
      if (cmd_i.load) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= x_sum;
      if (cfg_i.pixel_format == FMT_COLOR) begin
        y_q   <= y_row;
        val_q <= source_word_i;
      end else begin
        y_q   <= y_page;
        val_q <= PIXEL_ON;
      end
    end
  end

  assign status_o.has_result = |load_mask;
  assign status_o.last       = (mask_rest == '0);

  assign pixel_x_o     = x_q;
  assign pixel_y_o     = y_q + {14'd0, bit_idx};
  assign pixel_value_o = val_q;
  assign last_of_run_o = status_o.last;

endmodule

FILE: design/transparent_bitmap_blitter_unit.sv
// Top level of the transparent bitmap blitter: register file, controller and datapath.
// An item is taken while the controller is idle; each pixel write it causes then follows
// one per cycle while out_ready_i is high, n writes per item (n up to 8 in page mode, 0 or 1 in color
// mode), stepped through by the single mask register that holds the pending bits.
// The first write of an item is valid in the cycle after the item is taken.
// Reset clears the position counters and the controller; registers take their reset values.
module transparent_bitmap_blitter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Source word channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [15:0]                   source_word_i,
  // Pixel write channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [16:0]                   pixel_x_o,
  output logic [16:0]                   pixel_y_o,
  output logic [15:0]                   pixel_value_o,
  output logic                          last_of_run_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbb_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tbb_pkg::*;

  `include "assert_macros.svh"

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The register file holds the bitmap geometry, format, key and screen bounds.
  // Software must write it only while no item is in flight; the block does not enforce
  // this, and the datapath reads it directly without any shadow copy.
  tbb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The controller is idle and ready for an item, or emitting the writes of the
  // item it took. An item that causes no write leaves it idle.
  tbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // On load the datapath advances the column and row counters, latches the base
  // coordinates and builds a mask of pending writes: the page byte in page mode,
  // or a single bit in color mode that is set only for an unclipped, non-key
  // pixel. Each accepted write clears the lowest pending bit, whose index is the
  // row offset within the page.
  tbb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .source_word_i (source_word_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_value_o (pixel_value_o),
    .last_of_run_o (last_of_run_o)
  );

  // The block never takes an item while a write is being offered.
  `TBB_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "ready while output valid")
  // The final write of an item hands control back to the input side.
  `TBB_ASSERT_IMP(a_last_returns, out_valid_o && out_ready_i && last_of_run_o, ##1 in_ready_o,
    "not ready after last write")
  // Page mode always writes the value one.
  `TBB_ASSERT_IMP(a_page_value, out_valid_o && (cfg.pixel_format == FMT_PAGE),
    pixel_value_o == PIXEL_ON, "page mode value not one")

endmodule
